[rtl/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, entry layout and codes of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int ID_WIDTH       = 16;
    localparam int PRIORITY_WIDTH = 8;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W:0]   SUM_WRAP   = (PTR_W + 1)'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic [ID_WIDTH-1:0]       id;
        logic [PRIORITY_WIDTH-1:0] prio;
    } entry_t;

    // circular slot address of a position counted from the head
    function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_WRAP)
        begin
            sum = sum - SUM_WRAP;
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

[rtl/spq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/stable_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept sorted in a circular RAM; equal priorities
// leave in arrival order.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   start / busy        mode, ticket_id, priority_req
//  result    done (one cycle)    status, removed_id, removed_priority, occupancy
//
// remove reads the head slot from the RAM, then pops it. insert writes an
// empty queue directly; else a backward scan from the tail moves each strictly
// lower-priority entry one slot back and puts the new entry behind the first
// entry not lower, or at the front. empty remove and full insert skip busy;
// done pulses the cycle after the last busy cycle, or after acceptance when
// busy never rose; the receiver cannot stall. reset clears the state, count,
// head pointer and result registers; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               mode,
    input  logic [spq_pkg::ID_WIDTH-1:0]       ticket_id,
    input  logic [spq_pkg::PRIORITY_WIDTH-1:0] priority_req,
    output logic                               done,
    output logic [1:0]                         status,
    output logic [spq_pkg::ID_WIDTH-1:0]       removed_id,
    output logic [spq_pkg::PRIORITY_WIDTH-1:0] removed_priority,
    output logic [spq_pkg::CNT_W-1:0]          occupancy
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_FRONT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     pos_reg, pos_next;
    entry_t               new_reg, new_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [ID_WIDTH-1:0]  rid_reg, rid_next;
    logic [PRIORITY_WIDTH-1:0] rprio_reg, rprio_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic [PTR_W-1:0]     ram_raddr;
    entry_t               ram_rdata;

    logic [CNT_W-1:0]     count_m1;
    logic [CNT_W-1:0]     count_p1;
    logic [PTR_W-1:0]     pos_p1;
    logic [PTR_W-1:0]     pos_m1;
    entry_t               req_entry;

    assign count_m1  = count_reg - 1'b1;
    assign count_p1  = count_reg + 1'b1;
    assign pos_p1    = pos_reg + 1'b1;
    assign pos_m1    = pos_reg - 1'b1;
    assign req_entry = '{id: ticket_id, prio: priority_req};

    spq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        pos_next    = pos_reg;
        new_next    = new_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rid_next    = rid_reg;
        rprio_next  = rprio_reg;
        occ_next    = occ_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_wdata   = new_reg;
        ram_raddr   = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    new_next = req_entry;
                    if (mode == MODE_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_EMPTY;
                            rid_next    = '0;
                            rprio_next  = '0;
                            occ_next    = count_reg;
                        end
                        else
                        begin
                            state_next = ST_POP;
                        end
                    end
                    else if (count_reg == COUNT_FULL)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_FULL;
                        rid_next    = '0;
                        rprio_next  = '0;
                        occ_next    = count_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = req_entry;
                        count_next  = count_p1;
                        done_next   = 1'b1;
                        status_next = STATUS_DONE;
                        rid_next    = '0;
                        rprio_next  = '0;
                        occ_next    = count_p1;
                    end
                    else
                    begin
                        // scan backward from the tail
                        pos_next   = count_m1[PTR_W-1:0];
                        ram_raddr  = slot_addr(head_reg, count_m1[PTR_W-1:0]);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_POP:
            begin
                head_next   = slot_addr(head_reg, PTR_W'(1));
                count_next  = count_m1;
                done_next   = 1'b1;
                status_next = STATUS_DONE;
                rid_next    = ram_rdata.id;
                rprio_next  = ram_rdata.prio;
                occ_next    = count_m1;
                state_next  = ST_IDLE;
            end

            ST_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_addr(head_reg, pos_p1);
                if (ram_rdata.prio < new_reg.prio)
                begin
                    // strictly lower priority moves one slot back
                    ram_wdata = ram_rdata;
                    if (pos_reg == '0)
                    begin
                        state_next = ST_FRONT;
                    end
                    else
                    begin
                        pos_next  = pos_m1;
                        ram_raddr = slot_addr(head_reg, pos_m1);
                    end
                end
                else
                begin
                    ram_wdata   = new_reg;
                    count_next  = count_p1;
                    done_next   = 1'b1;
                    status_next = STATUS_DONE;
                    rid_next    = '0;
                    rprio_next  = '0;
                    occ_next    = count_p1;
                    state_next  = ST_IDLE;
                end
            end

            ST_FRONT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = head_reg;
                ram_wdata   = new_reg;
                count_next  = count_p1;
                done_next   = 1'b1;
                status_next = STATUS_DONE;
                rid_next    = '0;
                rprio_next  = '0;
                occ_next    = count_p1;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            head_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_DONE;
            rid_reg    <= '0;
            rprio_reg  <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            rid_reg    <= rid_next;
            rprio_reg  <= rprio_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        new_reg <= new_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign status           = status_reg;
    assign removed_id       = rid_reg;
    assign removed_priority = rprio_reg;
    assign occupancy        = occ_reg;

endmodule

[rtl/spq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic [1:0]                         status,
    input logic [spq_pkg::ID_WIDTH-1:0]       removed_id,
    input logic [spq_pkg::PRIORITY_WIDTH-1:0] removed_priority,
    input logic [spq_pkg::CNT_W-1:0]          occupancy
);
    import spq_pkg::*;

    // an accepted request either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request neither answered nor in progress");

    // busy only starts from an accepted request
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FULL) |-> (occupancy == COUNT_FULL &&
                                             removed_id == '0))
        else $error("full status with queue not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_EMPTY) |-> (occupancy == '0 &&
                                              removed_priority == '0))
        else $error("empty status with entries held");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupancy <= COUNT_FULL))
        else $error("occupancy beyond queue depth");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

[dv/stable_priority_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_test
// Drives insert and remove requests into the sorted priority queue, mirrors
// the sorted slots in a scoreboard and checks every done pulse field by field.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TIME  = 40;
    localparam int BURST_LEN    = 16;
    localparam int BURSTS       = 31;

    typedef struct {
        status_t                   status;
        logic [ID_WIDTH-1:0]       id;
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [CNT_W-1:0]          occ;
    } outcome_t;

    // sorted copy of the queue plus the results still owed by the block
    class spq_scoreboard;
        logic [ID_WIDTH-1:0]       slot_id [QUEUE_DEPTH];
        logic [PRIORITY_WIDTH-1:0] slot_prio [QUEUE_DEPTH];
        int                        held = 0;
        outcome_t                  owed[$];
        int                        fails = 0;
        int                        n_insert = 0;
        int                        n_remove = 0;
        int                        n_full = 0;
        int                        n_empty = 0;
        int                        peak = 0;

        function int pending();
            return owed.size();
        endfunction

        function void note_request(logic m, logic [ID_WIDTH-1:0] id,
                                   logic [PRIORITY_WIDTH-1:0] p);
            outcome_t o;
            int       pos;
            o.status = STATUS_DONE;
            o.id     = '0;
            o.prio   = '0;
            if (m == MODE_REMOVE)
            begin
                n_remove++;
                if (held == 0)
                begin
                    o.status = STATUS_EMPTY;
                    n_empty++;
                end
                else
                begin
                    o.id   = slot_id[0];
                    o.prio = slot_prio[0];
                    for (int i = 1; i < held; i++)
                    begin
                        slot_id[i-1]   = slot_id[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    held--;
                end
            end
            else
            begin
                n_insert++;
                if (held >= QUEUE_DEPTH)
                begin
                    o.status = STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    // behind every entry of greater or equal priority
                    pos = 0;
                    while (pos < held && slot_prio[pos] >= p)
                        pos++;
                    for (int i = held; i > pos; i--)
                    begin
                        slot_id[i]   = slot_id[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_id[pos]   = id;
                    slot_prio[pos] = p;
                    held++;
                    if (held > peak)
                        peak = held;
                end
            end
            o.occ = CNT_W'(held);
            owed.push_back(o);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            fails++;
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        endtask

        task check_result(logic [1:0] st, logic [ID_WIDTH-1:0] id,
                          logic [PRIORITY_WIDTH-1:0] p, logic [CNT_W-1:0] occ);
            outcome_t o;
            if (owed.size() == 0)
            begin
                report("result with no request outstanding, status", st, 0);
            end
            else
            begin
                o = owed.pop_front();
                if (st !== o.status)
                    report("status", st, o.status);
                if (id !== o.id)
                    report("removed_id", id, o.id);
                if (p !== o.prio)
                    report("removed_priority", p, o.prio);
                if (occ !== o.occ)
                    report("occupancy", occ, o.occ);
            end
        endtask

        task drain_check();
            if (owed.size() != 0)
                report("results never delivered, count", 0, owed.size());
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      mode = MODE_INSERT;
    logic [ID_WIDTH-1:0]       ticket_id = '0;
    logic [PRIORITY_WIDTH-1:0] priority_req = '0;
    logic                      done;
    logic [1:0]                status;
    logic [ID_WIDTH-1:0]       removed_id;
    logic [PRIORITY_WIDTH-1:0] removed_priority;
    logic [CNT_W-1:0]          occupancy;

    spq_scoreboard queue_model = new();
    int            cycles = 0;

    stable_priority_queue dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .ticket_id        (ticket_id),
        .priority_req     (priority_req),
        .done             (done),
        .status           (status),
        .removed_id       (removed_id),
        .removed_priority (removed_priority),
        .occupancy        (occupancy)
    );

    always #10 clk = ~clk;

    // request acceptance and result strobes, both sampled at the edge
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (start && !busy)
                queue_model.note_request(mode, ticket_id, priority_req);
            if (done)
                queue_model.check_result(status, removed_id, removed_priority, occupancy);
        end
    end

    // returns at the edge that accepts the request, start left high
    task automatic issue(logic m, logic [ID_WIDTH-1:0] id, logic [PRIORITY_WIDTH-1:0] p);
        start        <= 1'b1;
        mode         <= m;
        ticket_id    <= id;
        priority_req <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct && n < 60)
            n++;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (queue_model.pending() != 0);
    endtask

    initial
    begin
        int                        sender_idle_pct [4];
        int                        burst_idle;
        int                        insert_pct;
        int                        narrow;
        logic [PRIORITY_WIDTH-1:0] base;
        logic [PRIORITY_WIDTH-1:0] p;
        logic [ID_WIDTH-1:0]       directed_id [4];
        logic [PRIORITY_WIDTH-1:0] directed_prio [8];

        // the receiver cannot stall, so its phase runs like the first one
        sender_idle_pct = '{0, 83, 0, 7};
        directed_id     = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
        directed_prio   = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h01, 8'h7F, 8'h80};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // remove from the empty queue, fill with ties and extremes, refuse one, remove four
        issue(MODE_REMOVE, 16'hFFFF, 8'hFF);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            issue(MODE_INSERT, (i < 4) ? directed_id[i] : ID_WIDTH'(i),
                  directed_prio[i % 8]);
        end
        issue(MODE_INSERT, 16'hFFFF, 8'hFF);
        repeat (4) issue(MODE_REMOVE, 16'h0000, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            pause_until_drained();
            for (int b = 0; b < BURSTS; b++)
            begin
                burst_idle = ($urandom_range(3) == 0) ? 0 : sender_idle_pct[ph];
                case ($urandom_range(3))
                    0: insert_pct = 10;
                    1: insert_pct = 40;
                    2: insert_pct = 60;
                    default: insert_pct = 90;
                endcase
                // narrow bands give plenty of equal priorities
                narrow = $urandom_range(2);
                base   = PRIORITY_WIDTH'($urandom);
                for (int k = 0; k < BURST_LEN; k++)
                begin
                    if (narrow != 0)
                        p = base + PRIORITY_WIDTH'($urandom_range(2));
                    else
                        p = PRIORITY_WIDTH'($urandom);
                    idle_cycles(burst_idle);
                    issue(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                          ID_WIDTH'($urandom), p);
                end
            end
        end

        pause_until_drained();
        repeat (SETTLE_TIME) @(posedge clk);
        queue_model.drain_check();

        $display("covered %0d inserts (%0d refused when full) and %0d removes (%0d on empty)",
                 queue_model.n_insert, queue_model.n_full,
                 queue_model.n_remove, queue_model.n_empty);
        $display("peak occupancy %0d of %0d, %0d mismatches",
                 queue_model.peak, QUEUE_DEPTH, queue_model.fails);
        if (queue_model.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
dv/stable_priority_queue_test.sv
